// ===== rtl/cdda_pkg.sv =====
// Shared types, constants and calendar helpers for the date day adder.
package cdda_pkg;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_ADD  = 1'b1;

  // Inverse of 25 modulo 2^32; truncate for narrower years.
  localparam logic [31:0] DIV25_INV = 32'hC28F5C29;
  localparam int YEAR_RESET = 2000;

  localparam logic [3:0] MONTH_JAN    = 4'd1;
  localparam logic [3:0] MONTH_FEB    = 4'd2;
  localparam logic [3:0] MONTH_DEC    = 4'd12;
  localparam logic [4:0] DAY_FIRST    = 5'd1;
  localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;
  localparam logic [4:0] DAYS_FEB      = 5'd28;
  localparam logic [4:0] DAYS_LONG     = 5'd31;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ADD,
    ST_DONE
  } cdda_state_t;

  typedef struct packed {
    logic start_load;
    logic start_add;
    logic add_step;
    logic out_write;
  } cdda_cmd_t;

  typedef struct packed {
    logic add_fits;
    logic out_free;
  } cdda_status_t;

  // Out-of-range months count as 31 days long.
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] d;
    d = DAYS_LONG;
    if (month == MONTH_FEB) begin
      d = leap ? DAYS_FEB_LEAP : DAYS_FEB;
    end else if (month >= MONTH_JAN && month <= MONTH_DEC) begin
      d = MONTH_LEN[month - MONTH_JAN];
    end
    return d;
  endfunction

endpackage

// ===== rtl/cdda_ctrl.sv =====
// Sequencer for the date day adder: load, month walk and result handoff.
module cdda_ctrl
  import cdda_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_action,
  output logic         in_ready,
  input  cdda_status_t status,
  output cdda_cmd_t    cmd
);

  cdda_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_action == ACT_ADD) ? ST_ADD : ST_LOAD;
        end
      end
      // Let the leap flag follow the loaded year before the handoff.
      ST_LOAD: state_nxt = ST_DONE;
      ST_ADD: begin
        if (status.add_fits) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.start_load = in_valid && (in_action == ACT_LOAD);
        cmd.start_add  = in_valid && (in_action == ACT_ADD);
      end
      ST_LOAD: ;
      ST_ADD:  cmd.add_step  = 1'b1;
      ST_DONE: cmd.out_write = status.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/cdda_dp.sv =====
// Datapath for the date day adder: date registers, month walk, leap flag, result.
module cdda_dp
  import cdda_pkg::*;
#(
  parameter int YEAR_BITS = 16,
  parameter int ADD_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cdda_cmd_t            cmd,
  output cdda_status_t         status,
  input  logic [YEAR_BITS-1:0] in_new_year,
  input  logic [3:0]           in_new_month,
  input  logic [4:0]           in_new_day,
  input  logic [ADD_BITS-1:0]  in_add_days,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [YEAR_BITS-1:0] out_cur_year,
  output logic [3:0]           out_cur_month,
  output logic [4:0]           out_cur_day,
  output logic                 out_year_wrapped
);

  localparam int REM_BITS = ADD_BITS + 1;
  localparam logic [YEAR_BITS-1:0] INV25 = DIV25_INV[YEAR_BITS-1:0];
  localparam logic [YEAR_BITS-1:0] DIV25_MAX =
    YEAR_BITS'(((64'd1 << YEAR_BITS) - 64'd1) / 64'd25);

  logic [YEAR_BITS-1:0] year_r;
  logic [3:0]           month_r;
  logic [4:0]           day_r;
  logic                 leap_r;
  logic                 wrap_r;
  logic [REM_BITS-1:0]  rem_r;
  logic                 out_valid_r;

  logic [4:0]           len;
  logic [REM_BITS-1:0]  len_ext;
  logic                 fits;
  logic [YEAR_BITS-1:0] ymul;
  logic                 div25;
  logic                 leap_nxt;

  // A multiple of 25 maps to at most DIV25_MAX under the modular inverse.
  assign ymul     = year_r * INV25;
  assign div25    = (ymul <= DIV25_MAX);
  assign leap_nxt = (year_r[1:0] == 2'b00) && (!div25 || (year_r[3:0] == 4'b0000));

  assign len     = month_days(month_r, leap_r);
  assign len_ext = REM_BITS'(len);
  assign fits    = (rem_r <= len_ext);

  // Register the leap flag from the year; the year changes only on a load or going into January.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leap_r <= 1'b1;
    end else begin
      leap_r <= leap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r  <= YEAR_BITS'(YEAR_RESET);
      month_r <= MONTH_JAN;
      day_r   <= DAY_FIRST;
      wrap_r  <= 1'b0;
    end else if (cmd.start_load) begin
      year_r  <= in_new_year;
      month_r <= in_new_month;
      day_r   <= in_new_day;
      wrap_r  <= 1'b0;
    end else if (cmd.start_add) begin
      wrap_r <= 1'b0;
    end else if (cmd.add_step) begin
      if (fits) begin
        day_r <= rem_r[4:0];
      end else if (month_r >= MONTH_DEC) begin
        month_r <= MONTH_JAN;
        if (year_r == '1) begin
          year_r <= '0;
          wrap_r <= 1'b1;
        end else begin
          year_r <= year_r + 1'b1;
        end
      end else begin
        month_r <= month_r + 1'b1;
      end
    end
  end

  // Scratch: day sum during an add.
  always_ff @(posedge clk) begin
    if (cmd.start_add) begin
      rem_r <= REM_BITS'(day_r) + REM_BITS'(in_add_days);
    end else if (cmd.add_step && !fits) begin
      rem_r <= rem_r - len_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_write) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_write) begin
      out_cur_year     <= year_r;
      out_cur_month    <= month_r;
      out_cur_day      <= day_r;
      out_year_wrapped <= wrap_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign status.add_fits = fits;
  assign status.out_free = !out_valid_r || out_ready;

endmodule

// ===== rtl/calendar_date_day_adder.sv =====
// Top level of the calendar date day adder: controller plus datapath.
//
// Holds a Gregorian date (year, month, day). Each input transaction either
// loads a date (in_action = 0) or adds in_add_days days (in_action = 1), and
// yields exactly one output transaction with the resulting date and a flag
// that the year wrapped past its maximum during that add.
// Both channels are valid/ready. A transaction is taken only while the
// sequencer is idle; the result sits in an output register, so the next
// input transaction is accepted while that result still waits for out_ready.
// A load reaches the result register after the sequencer's load state (for the
// leap flag to follow the new year) and its handoff state; an add walks month
// by month, with a single month-length subtract per step of the walk loop
// (about 2200 months for the largest 16-bit day count), then hands off. Input
// is ready again the cycle after the result is written.
// If out_ready stays low while an earlier result waits, the finished result
// holds and the sequencer waits in its handoff state. Reset (rst_n low,
// synchronous) sets the date to January 1, 2000 and drops any pending result.
module calendar_date_day_adder
  import cdda_pkg::*;
#(
  parameter int YEAR_BITS = 16,
  parameter int ADD_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [YEAR_BITS-1:0] in_new_year,
  input  logic [3:0]           in_new_month,
  input  logic [4:0]           in_new_day,
  input  logic [ADD_BITS-1:0]  in_add_days,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [YEAR_BITS-1:0] out_cur_year,
  output logic [3:0]           out_cur_month,
  output logic [4:0]           out_cur_day,
  output logic                 out_year_wrapped
);

  cdda_cmd_t    cmd;
  cdda_status_t status;

  // Sequence load, month walk and result handoff.
  cdda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold the date, walk months, track the leap flag, register the result.
  cdda_dp #(
    .YEAR_BITS (YEAR_BITS),
    .ADD_BITS  (ADD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_new_year      (in_new_year),
    .in_new_month     (in_new_month),
    .in_new_day       (in_new_day),
    .in_add_days      (in_add_days),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cur_year     (out_cur_year),
    .out_cur_month    (out_cur_month),
    .out_cur_day      (out_cur_day),
    .out_year_wrapped (out_year_wrapped)
  );

endmodule
